@@ sv/grid_ray_cast_distance_macros.svh @@
// Assertion helpers used by the march engine RTL.
`ifndef GRID_RAY_CAST_DISTANCE_MACROS_SVH
`define GRID_RAY_CAST_DISTANCE_MACROS_SVH
`ifndef SYNTHESIS
`define GRCD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("grcd assertion failed");
`define GRCD_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("grcd forbidden condition seen");
`else
`define GRCD_ASSERT(lbl, prop)
`define GRCD_NEVER(lbl, cond)
`endif
`endif

@@ sv/grcd_pkg.sv @@
package grcd_pkg;

  localparam int GRID_ROWS    = 6;
  localparam int GRID_COLUMNS = 8;
  localparam int CELL_UNITS   = 10;
  localparam int CELL         = CELL_UNITS * 256;
  localparam int MAP_W        = 48;
  localparam int TRIG_EPS     = 16;
  localparam int CORDIC_STEPS = 14;
  localparam int CORDIC_START = 9949;
  localparam int MAX_Q        = 32767 / CELL;

  localparam logic [MAP_W-1:0] MAP_RESET = 48'hFF8185D591FF;
  localparam logic [0:0] ADDR_WALL_MAP = 1'b0;

  // Origin and CORDIC result carried from the front end to the march engine.
  typedef struct packed {
    logic [14:0]        ox;
    logic [13:0]        oy;
    logic signed [15:0] cs;
    logic signed [15:0] sn;
  } ray_t;

  function automatic logic [13:0] atan_units(input logic [3:0] i);
    logic [13:0] v;
    case (i)
      4'd0: v = 14'd8192;
      4'd1: v = 14'd4836;
      4'd2: v = 14'd2555;
      4'd3: v = 14'd1297;
      4'd4: v = 14'd651;
      4'd5: v = 14'd326;
      4'd6: v = 14'd163;
      4'd7: v = 14'd81;
      4'd8: v = 14'd41;
      4'd9: v = 14'd20;
      4'd10: v = 14'd10;
      4'd11: v = 14'd5;
      4'd12: v = 14'd3;
      4'd13: v = 14'd1;
      default: v = 14'd0;
    endcase
    return v;
  endfunction

  // Remainder of a 15-bit value modulo one cell, by parallel compares.
  function automatic logic [15:0] mod_cell(input logic [14:0] v);
    int q;
    q = 0;
    for (int r = 1; r <= MAX_Q; r++) begin
      if (int'(v) >= r * CELL) q = r;
    end
    return 16'(int'(v) - q * CELL);
  endfunction

  function automatic logic is_wall(input logic [MAP_W-1:0] map,
                                   input logic signed [31:0] px,
                                   input logic signed [31:0] py);
    int row;
    int col;
    int bidx;
    logic w;
    row = 0;
    col = 0;
    w = 1'b0;
    if (px >= 0 && py >= 0 && px < GRID_COLUMNS * CELL && py < GRID_ROWS * CELL) begin
      for (int r = 1; r < GRID_ROWS; r++) begin
        if (py >= r * CELL) row = r;
      end
      for (int c = 1; c < GRID_COLUMNS; c++) begin
        if (px >= c * CELL) col = c;
      end
      bidx = row * GRID_COLUMNS + col;
      if (bidx < MAP_W) w = map[bidx[5:0]];
    end
    return w;
  endfunction

endpackage

@@ sv/grcd_front.sv @@
module grcd_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [14:0]          in_ray_x,
  input  logic [13:0]          in_ray_y,
  input  logic [11:0]          in_ray_angle,
  input  logic                 q_full,
  output logic                 q_push,
  output grcd_pkg::ray_t       q_data
);

  logic               busy_r;
  logic               done_r;
  logic [3:0]         iter_r;
  logic signed [15:0] x_r;
  logic signed [15:0] y_r;
  logic signed [16:0] z_r;
  logic [1:0]         quad_r;
  logic [14:0]        ox_r;
  logic [13:0]        oy_r;
  logic signed [15:0] xs;
  logic signed [15:0] ys;
  logic signed [16:0] at;

  function automatic logic signed [15:0] tshr(input logic signed [15:0] v,
                                              input logic [3:0] s);
    logic signed [15:0] m;
    m = (v < 0) ? -v : v;
    m = m >>> s;
    return (v < 0) ? -m : m;
  endfunction

  assign in_stall = busy_r;
  assign q_push   = busy_r && done_r && !q_full;
  assign xs = tshr(x_r, iter_r);
  assign ys = tshr(y_r, iter_r);
  assign at = 17'(grcd_pkg::atan_units(iter_r));

  always_comb begin
    q_data.ox = ox_r;
    q_data.oy = oy_r;
    case (quad_r)
      2'd0: begin
        q_data.cs = x_r;
        q_data.sn = y_r;
      end
      2'd1: begin
        q_data.cs = -y_r;
        q_data.sn = x_r;
      end
      2'd2: begin
        q_data.cs = -x_r;
        q_data.sn = -y_r;
      end
      default: begin
        q_data.cs = y_r;
        q_data.sn = -x_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else if (!busy_r) begin
      if (in_valid) begin
        busy_r <= 1'b1;
        done_r <= 1'b0;
        iter_r <= '0;
        x_r    <= 16'(grcd_pkg::CORDIC_START);
        y_r    <= '0;
        z_r    <= 17'({in_ray_angle[9:0], 4'b0000});
        quad_r <= in_ray_angle[11:10];
        ox_r   <= in_ray_x;
        oy_r   <= in_ray_y;
      end
    end else if (!done_r) begin
      if (z_r >= 0) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + at;
      end
      iter_r <= iter_r + 4'd1;
      if (iter_r == 4'(grcd_pkg::CORDIC_STEPS - 1)) done_r <= 1'b1;
    end else if (!q_full) begin
      busy_r <= 1'b0;
    end
  end

endmodule

@@ sv/grcd_fifo.sv @@
module grcd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  grcd_pkg::ray_t wr_data,
  input  logic           pop,
  output grcd_pkg::ray_t rd_data,
  output logic           full,
  output logic           empty
);

  grcd_pkg::ray_t mem_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     count_r;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop) rd_ptr_r <= !rd_ptr_r;
      if (push && !pop) count_r <= count_r + 2'd1;
      else if (pop && !push) count_r <= count_r - 2'd1;
    end
  end

endmodule

@@ sv/grcd_back.sv @@
`include "grid_ray_cast_distance_macros.svh"

module grcd_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [grcd_pkg::MAP_W-1:0]  wall_map,
  input  logic                        q_empty,
  input  grcd_pkg::ray_t              q_data,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [15:0]                 out_hit_distance
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SETUP = 4'd1;
  localparam logic [3:0] S_MUL   = 4'd2;
  localparam logic [3:0] S_DIV   = 4'd3;
  localparam logic [3:0] S_TEST  = 4'd4;
  localparam logic [3:0] S_SQA   = 4'd5;
  localparam logic [3:0] S_SQB   = 4'd6;
  localparam logic [3:0] S_SQRT  = 4'd7;
  localparam logic [3:0] S_RES   = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0]          state_r;
  grcd_pkg::ray_t      ray_r;
  logic                vert_r;
  logic [3:0]          k_r;
  logic signed [17:0]  da_r;
  logic                step_pos_r;
  logic                neg_r;
  logic [14:0]         rem_r;
  logic [29:0]         quo_r;
  logic [4:0]          cnt_r;
  logic signed [31:0]  db_r;
  logic [32:0]         val_r;
  logic [32:0]         res_r;
  logic [32:0]         bit_r;
  logic                sat_r;
  logic [15:0]         d1_r;
  logic [15:0]         fin_r;
  logic                out_valid_r;
  logic [15:0]         out_hit_distance_r;

  logic signed [15:0]  dir;
  logic signed [15:0]  other;
  logic [14:0]         along;
  logic [14:0]         den;
  logic [3:0]          last;
  logic signed [33:0]  prod;
  logic [33:0]         prod_mag;
  logic [15:0]         trial;
  logic signed [31:0]  db;
  logic signed [31:0]  px;
  logic signed [31:0]  py;
  logic                hit;
  logic [17:0]         ada;
  logic [31:0]         adb;
  logic [32:0]         rb;
  logic [15:0]         dist_sat;
  logic [15:0]         rm;
  logic                load_out;

  assign dir   = vert_r ? ray_r.cs : ray_r.sn;
  assign other = vert_r ? ray_r.sn : ray_r.cs;
  assign along = vert_r ? ray_r.ox : 15'(ray_r.oy);
  assign den   = (dir < 0) ? 15'(-dir) : 15'(dir);
  assign last  = vert_r ? 4'(grcd_pkg::GRID_COLUMNS + 1) : 4'(grcd_pkg::GRID_ROWS + 1);
  assign rm    = grcd_pkg::mod_cell(along);
  assign prod     = da_r * other;
  assign prod_mag = (prod < 0) ? 34'(-prod) : 34'(prod);
  assign trial    = {rem_r, quo_r[29]};
  assign db       = neg_r ? -32'(quo_r) : 32'(quo_r);

  always_comb begin
    if (vert_r) begin
      px  = 32'(ray_r.ox) + 32'(da_r);
      py  = 32'(ray_r.oy) + db;
      hit = grcd_pkg::is_wall(wall_map, px - 32'sd256, py)
         || grcd_pkg::is_wall(wall_map, px, py);
    end else begin
      px  = 32'(ray_r.ox) + db;
      py  = 32'(ray_r.oy) + 32'(da_r);
      hit = grcd_pkg::is_wall(wall_map, px, py - 32'sd256)
         || grcd_pkg::is_wall(wall_map, px, py);
    end
  end

  assign ada  = (da_r < 0) ? 18'(-da_r) : 18'(da_r);
  assign adb  = (db_r < 0) ? 32'(-db_r) : 32'(db_r);
  assign rb   = res_r + bit_r;
  assign dist_sat = (sat_r || res_r > 33'd65535) ? 16'hFFFF : res_r[15:0];
  assign q_pop    = (state_r == S_IDLE) && !q_empty;
  assign load_out = (state_r == S_DONE) && (!out_valid_r || !out_stall);
  assign out_valid        = out_valid_r;
  assign out_hit_distance = out_hit_distance_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      vert_r      <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_r        <= 1'b1;
        out_hit_distance_r <= fin_r;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            ray_r   <= q_data;
            vert_r  <= 1'b0;
            k_r     <= '0;
            state_r <= S_SETUP;
          end
        end
        S_SETUP: begin
          k_r <= '0;
          if (dir >= -16'(grcd_pkg::TRIG_EPS) && dir <= 16'(grcd_pkg::TRIG_EPS)) begin
            sat_r   <= 1'b1;
            state_r <= S_RES;
          end else begin
            sat_r      <= 1'b0;
            step_pos_r <= (dir > 0);
            da_r       <= (dir > 0) ? 18'(grcd_pkg::CELL) - 18'(rm) : -18'(rm);
            state_r    <= S_MUL;
          end
        end
        S_MUL: begin
          neg_r   <= prod[33] ^ dir[15];
          quo_r   <= prod_mag[29:0];
          rem_r   <= '0;
          cnt_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (trial >= 16'(den)) begin
            rem_r <= 15'(trial - 16'(den));
            quo_r <= {quo_r[28:0], 1'b1};
          end else begin
            rem_r <= trial[14:0];
            quo_r <= {quo_r[28:0], 1'b0};
          end
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd29) state_r <= S_TEST;
        end
        S_TEST: begin
          if (k_r == last || hit) begin
            db_r    <= db;
            state_r <= S_SQA;
          end else begin
            k_r     <= k_r + 4'd1;
            da_r    <= step_pos_r ? da_r + 18'(grcd_pkg::CELL) : da_r - 18'(grcd_pkg::CELL);
            state_r <= S_MUL;
          end
        end
        S_SQA: begin
          if (ada[17:16] != 2'b00 || adb[31:16] != 16'd0) begin
            sat_r   <= 1'b1;
            state_r <= S_RES;
          end else begin
            val_r   <= 33'(ada[15:0]) * 33'(ada[15:0]);
            state_r <= S_SQB;
          end
        end
        S_SQB: begin
          val_r   <= val_r + 33'(adb[15:0]) * 33'(adb[15:0]);
          res_r   <= '0;
          bit_r   <= 33'h1_0000_0000;
          state_r <= S_SQRT;
        end
        S_SQRT: begin
          if (val_r >= rb) begin
            val_r <= val_r - rb;
            res_r <= (res_r >> 1) + bit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r <= bit_r >> 2;
          if (bit_r[0]) state_r <= S_RES;
        end
        S_RES: begin
          if (!vert_r) begin
            d1_r    <= dist_sat;
            vert_r  <= 1'b1;
            state_r <= S_SETUP;
          end else begin
            fin_r   <= (d1_r < dist_sat) ? d1_r : dist_sat;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (load_out) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `GRCD_ASSERT(a_pop_idle, q_pop |-> state_r == S_IDLE)
  `GRCD_ASSERT(a_out_from_done, $rose(out_valid_r) |-> $past(state_r == S_DONE))
  `GRCD_NEVER(a_k_bound, k_r > last)

endmodule

@@ sv/grid_ray_cast_distance.sv @@
// Grid ray cast distance: each item is a ray origin (Q.8 map units) and a 12-bit
// binary angle; the result item is the distance to the nearest wall crossing in
// the grid held by the 64-bit wall_map register at APB address 0 (low 48 bits
// used, one bit per cell, row-major), saturated at 65535. The front end runs a
// CORDIC for sine and cosine and hands rays to a two-entry queue, so a new ray
// is taken while the march engine still works on earlier ones. The march engine
// walks horizontal then vertical grid lines; every crossing costs a multiply, a
// bit-serial divide and a wall test, and the march stops at a wall or after the
// last grid line, then the distance needs squaring and a bit-serial square root.
// The result sits in an output register so the engine can start the next ray
// while the result waits to be taken.
module grid_ray_cast_distance (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [14:0] in_ray_x,
  input  logic [13:0] in_ray_y,
  input  logic [11:0] in_ray_angle,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_hit_distance,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [grcd_pkg::MAP_W-1:0] wall_map_r;
  logic                       q_full;
  logic                       q_empty;
  logic                       q_push;
  logic                       q_pop;
  grcd_pkg::ray_t             q_wr;
  grcd_pkg::ray_t             q_rd;

  // The register port never waits; writes land on the access cycle.
  assign pready = 1'b1;
  assign prdata = (paddr == grcd_pkg::ADDR_WALL_MAP) ? 64'(wall_map_r) : 64'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wall_map_r <= grcd_pkg::MAP_RESET;
    end else if (psel && penable && pwrite && paddr == grcd_pkg::ADDR_WALL_MAP) begin
      wall_map_r <= pwdata[grcd_pkg::MAP_W-1:0];
    end
  end

  // Front end: takes the ray and produces sine and cosine.
  grcd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_ray_x     (in_ray_x),
    .in_ray_y     (in_ray_y),
    .in_ray_angle (in_ray_angle),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_wr)
  );

  // Queue between the two halves so each can stall on its own.
  grcd_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr),
    .pop     (q_pop),
    .rd_data (q_rd),
    .full    (q_full),
    .empty   (q_empty)
  );

  // March engine: both grid marches, divider, square root and the result register.
  grcd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .wall_map         (wall_map_r),
    .q_empty          (q_empty),
    .q_data           (q_rd),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_hit_distance (out_hit_distance)
  );

endmodule
